### rtl/core/slm_pkg.sv
// ----------------------------------------------------------------------------
// slm_pkg
// Shared types and constants for the LIKE pattern matcher.
// ----------------------------------------------------------------------------
package slm_pkg;

    localparam int MAX_PATTERN_DEF = 32;

    localparam logic [7:0] CH_PERCENT    = 8'h25;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] ESCAPE_RESET  = 8'h5C;

    typedef enum logic [1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_APPEND = 2'd1,
        FUNC_BYTE   = 2'd2,
        FUNC_END    = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        KIND_LIT = 2'd0,
        KIND_ONE = 2'd1,
        KIND_RUN = 2'd2,
        KIND_ESC = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] chr;
    } tok_t;

    // Broadcast controls from the top level to every cell.
    typedef struct packed {
        logic       clear;
        logic       rearm;
        logic       stream;
        logic [7:0] chr;
        tok_t       wr_tok;
    } ctrl_t;

    // Signals handed from one cell to the next.
    typedef struct packed {
        logic adv;
        logic carry;
    } link_t;

endpackage

### rtl/core/slm_cell.sv
// ----------------------------------------------------------------------------
// slm_cell
// One pattern position: holds its token, a used flag and the seed bit of the
// active set; closes over any-run tokens and steps on a string byte.
// ----------------------------------------------------------------------------
module slm_cell #(
    parameter logic IS_START = 1'b0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  slm_pkg::ctrl_t ctrl,
    input  logic           we,
    input  slm_pkg::link_t link_in,
    output slm_pkg::link_t link_out,
    output logic           active,
    output logic           used
);

    slm_pkg::tok_t tok_reg;
    slm_pkg::tok_t tok_next;
    logic          used_reg;
    logic          used_next;
    logic          seed_reg;
    logic          seed_next;
    logic          closed;
    logic          is_run;
    logic          step_hit;

    assign closed   = seed_reg | link_in.carry;
    assign is_run   = (tok_reg.kind == slm_pkg::KIND_RUN);
    assign step_hit = (tok_reg.kind == slm_pkg::KIND_ONE)
                   || (!is_run && (tok_reg.chr == ctrl.chr));

    assign link_out.carry = closed & used_reg & is_run;
    assign link_out.adv   = closed & used_reg & step_hit;
    assign active         = closed;
    assign used           = used_reg;

    always_comb
    begin
        tok_next  = we ? ctrl.wr_tok : tok_reg;
        used_next = used_reg;
        if (ctrl.clear)
        begin
            used_next = 1'b0;
        end
        else if (we)
        begin
            used_next = 1'b1;
        end
        seed_next = seed_reg;
        if (ctrl.rearm)
        begin
            seed_next = IS_START;
        end
        else if (ctrl.stream)
        begin
            seed_next = (closed & used_reg & is_run) | link_in.adv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            seed_reg <= IS_START;
        end
        else
        begin
            used_reg <= used_next;
            seed_reg <= seed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
    end

endmodule

### rtl/core/sql_like_matcher_unit.sv
// ----------------------------------------------------------------------------
// sql_like_matcher_unit
// Streaming SQL LIKE matcher with escape byte, built as a row of position
// cells that carry the active set of pattern positions.
//
//   channel  handshake            payload
//   -------  -------------------  --------------------------------
//   cfg      cfg_valid/cfg_ready  escape_char
//   in       in_valid/in_ready    func, byte_value, is_null
//   out      out_valid/out_ready  match, pattern_error
//
// A new input word is taken each cycle while in_ready is high.
// The any-run closure ripples combinationally through the cell row.
// An end-of-string result appears in the output register the next cycle.
// in_ready drops only while a result waits and out_ready is low.
// Reset empties the pattern and restores the escape byte to backslash.
// ----------------------------------------------------------------------------
module sql_like_matcher_unit #(
    parameter int MAX_PATTERN = slm_pkg::MAX_PATTERN_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] escape_char,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] func,
    input  logic [7:0] byte_value,
    input  logic       is_null,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       match,
    output logic       pattern_error
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    logic [7:0]       esc_reg;
    logic [7:0]       esc_next;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic             pend_reg;
    logic             pend_next;
    logic             bad_reg;
    logic             bad_next;
    logic             tail_reg;
    logic             tail_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             match_reg;
    logic             match_next;
    logic             err_reg;
    logic             err_next;

    slm_pkg::func_t   fn;
    slm_pkg::ctrl_t   ctrl;
    logic             accept;
    logic             append;
    logic             full;
    logic             err;
    logic             hit;
    logic             tail_active;

    slm_pkg::link_t   links  [MAX_PATTERN+1];
    logic [MAX_PATTERN-1:0] act;
    logic [MAX_PATTERN-1:0] usd;
    logic [MAX_PATTERN-1:0] last;

    assign fn        = slm_pkg::func_t'(func);
    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign full      = (len_reg == LEN_W'(MAX_PATTERN));

    assign links[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_PATTERN; gi++)
        begin : g_cell
            slm_cell #(
                .IS_START((gi == 0) ? 1'b1 : 1'b0)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .we       (append && (len_reg == LEN_W'(gi))),
                .link_in  (links[gi]),
                .link_out (links[gi+1]),
                .active   (act[gi]),
                .used     (usd[gi])
            );
            if (gi == 0)
            begin : g_first
                assign last[gi] = !usd[gi];
            end
            else
            begin : g_rest
                assign last[gi] = usd[gi-1] && !usd[gi];
            end
        end
    endgenerate

    assign tail_active = tail_reg | links[MAX_PATTERN].carry;

    always_comb
    begin
        ctrl           = '0;
        ctrl.chr       = byte_value;
        ctrl.wr_tok    = '{kind: slm_pkg::KIND_LIT, chr: byte_value};
        append         = 1'b0;
        esc_next       = (cfg_valid && cfg_ready) ? escape_char : esc_reg;
        len_next       = len_reg;
        pend_next      = pend_reg;
        bad_next       = bad_reg;
        tail_next      = tail_reg;
        err            = bad_reg || pend_reg;
        hit            = !is_null && !err
                      && ((|(act & last)) || (usd[MAX_PATTERN-1] && tail_active));
        out_valid_next = out_valid_reg && !out_ready;
        match_next     = match_reg;
        err_next       = err_reg;
        if (accept)
        begin
            unique case (fn)
                slm_pkg::FUNC_CLEAR:
                begin
                    ctrl.clear = 1'b1;
                    ctrl.rearm = 1'b1;
                    len_next   = '0;
                    pend_next  = 1'b0;
                    bad_next   = 1'b0;
                    tail_next  = 1'b0;
                end
                slm_pkg::FUNC_APPEND:
                begin
                    ctrl.rearm = 1'b1;
                    tail_next  = 1'b0;
                    if (pend_reg)
                    begin
                        ctrl.wr_tok.kind = slm_pkg::KIND_ESC;
                        append           = 1'b1;
                        pend_next        = 1'b0;
                    end
                    else if (byte_value == esc_reg)
                    begin
                        pend_next = 1'b1;
                    end
                    else
                    begin
                        append = 1'b1;
                        if (byte_value == slm_pkg::CH_PERCENT)
                        begin
                            ctrl.wr_tok.kind = slm_pkg::KIND_RUN;
                        end
                        else if (byte_value == slm_pkg::CH_UNDERSCORE)
                        begin
                            ctrl.wr_tok.kind = slm_pkg::KIND_ONE;
                        end
                    end
                    if (append && full)
                    begin
                        append   = 1'b0;
                        bad_next = 1'b1;
                    end
                    else if (append)
                    begin
                        len_next = len_reg + LEN_W'(1);
                    end
                end
                slm_pkg::FUNC_BYTE:
                begin
                    ctrl.stream = 1'b1;
                    tail_next   = links[MAX_PATTERN].adv;
                end
                slm_pkg::FUNC_END:
                begin
                    ctrl.rearm     = 1'b1;
                    tail_next      = 1'b0;
                    out_valid_next = 1'b1;
                    match_next     = hit;
                    err_next       = err;
                end
                default:
                begin
                    ctrl.rearm = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg       <= slm_pkg::ESCAPE_RESET;
            len_reg       <= '0;
            pend_reg      <= 1'b0;
            bad_reg       <= 1'b0;
            tail_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            esc_reg       <= esc_next;
            len_reg       <= len_next;
            pend_reg      <= pend_next;
            bad_reg       <= bad_next;
            tail_reg      <= tail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        match_reg <= match_next;
        err_reg   <= err_next;
    end

    assign out_valid     = out_valid_reg;
    assign match         = match_reg;
    assign pattern_error = err_reg;

endmodule
